FILE: design/tumbx_pkg.sv
// Package for the training-unit mailbox register block.
// Holds the address map, message codes, command codes and shared types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tumbx_pkg;

    localparam int ADDR_W  = 20;
    localparam int DATA_W  = 16;
    localparam int MSG_W   = 8;

    // Message queue of the mailbox.
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Data RAM window.
    localparam int DATA_RAM_WORDS = 8192;
    localparam int DRAM_AW        = $clog2(DATA_RAM_WORDS);

    // Command queue between the decoder and the execution side.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PW    = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    // Address map.
    localparam logic [ADDR_W-1:0] IMEM_BASE = 20'h50000;
    localparam logic [ADDR_W-1:0] DMEM_BASE = 20'h54000;
    localparam logic [ADDR_W-1:0] DMEM_END  = 20'h56000;
    localparam logic [ADDR_W-1:0] REG_RESET = 20'hd0099;
    localparam logic [ADDR_W-1:0] REG_READY = 20'hd0004;
    localparam logic [ADDR_W-1:0] REG_ACK   = 20'hd0031;
    localparam logic [ADDR_W-1:0] REG_DATA  = 20'hd0032;
    localparam logic [ADDR_W-1:0] REG_ONE_A = 20'hd00fa;
    localparam logic [ADDR_W-1:0] REG_ONE_B = 20'h200c9;

    localparam logic [MSG_W-1:0] MSG_STARTED  = 8'ha0;
    localparam logic [MSG_W-1:0] MSG_FINISHED = 8'h07;

    // Handshake states.
    localparam logic [1:0] HS_IDLE      = 2'd0;
    localparam logic [1:0] HS_WAIT_LOW  = 2'd1;
    localparam logic [1:0] HS_WAIT_HIGH = 2'd2;

    // Decoded command codes.
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
    localparam logic [OP_W-1:0] OP_RAM_RD   = 4'd1;
    localparam logic [OP_W-1:0] OP_RAM_WR   = 4'd2;
    localparam logic [OP_W-1:0] OP_RST_WR   = 4'd3;
    localparam logic [OP_W-1:0] OP_ACK_WR   = 4'd4;
    localparam logic [OP_W-1:0] OP_RD_RESET = 4'd5;
    localparam logic [OP_W-1:0] OP_RD_READY = 4'd6;
    localparam logic [OP_W-1:0] OP_RD_MBOX  = 4'd7;
    localparam logic [OP_W-1:0] OP_RD_ACK   = 4'd8;
    localparam logic [OP_W-1:0] OP_RD_ONE   = 4'd9;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [DRAM_AW-1:0] ram_addr;
        logic [DATA_W-1:0]  wdata;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cmdq_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

`default_nettype wire

FILE: design/training_unit_mailbox_registers_top.sv
// Top level of the training-unit mailbox register block.
// Instantiates tumbx_front, tumbx_cmdq and tumbx_back; depends on tumbx_pkg.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    s_func, s_addr, s_write_data
//   m_       out        m_valid/m_ready    m_read_data
//
// Each accepted item yields exactly one result, one item per cycle sustained while
// m_ready stays high. An accepted item passes through the command queue and then
// the result register, which also holds the registered RAM read data.
// After reset the data RAM is zeroed in a sweep over all 8192 words; s_ready stays
// low until it ends. A stalled m_ side fills the two-entry command queue and
// then drops s_ready.
`timescale 1ns / 1ps
`default_nettype none

module training_unit_mailbox_registers_top
    import tumbx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_func,
    input  wire logic [ADDR_W-1:0] s_addr,
    input  wire logic [DATA_W-1:0] s_write_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_read_data
);

    cmdq_status_t cmdq_status;
    back_status_t back_status;
    logic         push;
    logic         pop;
    cmd_t         push_cmd;
    cmd_t         head_cmd;

    tumbx_front u_front (
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_addr       (s_addr),
        .s_write_data (s_write_data),
        .cmdq_status  (cmdq_status),
        .back_status  (back_status),
        .push         (push),
        .push_cmd     (push_cmd)
    );

    tumbx_cmdq u_cmdq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (cmdq_status)
    );

    tumbx_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmdq_status (cmdq_status),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .status      (back_status),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_data (m_read_data)
    );

endmodule

`default_nettype wire

FILE: design/tumbx_front.sv
// Front side: accepts bus items and decodes each address into a command.
// Depends on tumbx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tumbx_front
    import tumbx_pkg::*;
(
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_func,
    input  wire logic [ADDR_W-1:0] s_addr,
    input  wire logic [DATA_W-1:0] s_write_data,
    input  wire cmdq_status_t      cmdq_status,
    input  wire back_status_t      back_status,
    output logic                   push,
    output cmd_t                   push_cmd
);

    logic              in_dmem;
    logic [ADDR_W-1:0] dmem_off;

    assign s_ready  = !cmdq_status.full && !back_status.clearing;
    assign push     = s_valid && s_ready;
    assign in_dmem  = (s_addr >= DMEM_BASE) && (s_addr < DMEM_END);
    assign dmem_off = s_addr - DMEM_BASE;

    always_comb begin
        push_cmd.ram_addr = dmem_off[DRAM_AW-1:0];
        push_cmd.wdata    = s_write_data;
        push_cmd.op       = OP_NONE;
        // Instruction memory and unmapped addresses fall through to OP_NONE.
        if (s_func) begin
            if (in_dmem) begin
                push_cmd.op = OP_RAM_WR;
            end else if (s_addr == REG_RESET) begin
                push_cmd.op = OP_RST_WR;
            end else if (s_addr == REG_ACK) begin
                push_cmd.op = OP_ACK_WR;
            end
        end else begin
            if (in_dmem) begin
                push_cmd.op = OP_RAM_RD;
            end else if (s_addr == REG_RESET) begin
                push_cmd.op = OP_RD_RESET;
            end else if (s_addr == REG_READY) begin
                push_cmd.op = OP_RD_READY;
            end else if (s_addr == REG_DATA) begin
                push_cmd.op = OP_RD_MBOX;
            end else if (s_addr == REG_ACK) begin
                push_cmd.op = OP_RD_ACK;
            end else if (s_addr == REG_ONE_A || s_addr == REG_ONE_B) begin
                push_cmd.op = OP_RD_ONE;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/tumbx_cmdq.sv
// Short command queue between the decoder and the execution side.
// Depends on tumbx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tumbx_cmdq
    import tumbx_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    input  wire logic  pop,
    output cmd_t       head_cmd,
    output cmdq_status_t status
);

    cmd_t               entry_reg [CMDQ_DEPTH];
    logic [CMDQ_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMDQ_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMDQ_CW-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CMDQ_CW'(CMDQ_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == CMDQ_PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: design/tumbx_back.sv
// Execution side: data RAM, mailbox registers, message queue and the result
// register. Clears the data RAM after reset. Depends on tumbx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tumbx_back
    import tumbx_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire cmdq_status_t      cmdq_status,
    input  wire cmd_t              head_cmd,
    output logic                   pop,
    output back_status_t           status,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_read_data
);

    logic [DATA_W-1:0] dram [DATA_RAM_WORDS];
    logic [DATA_W-1:0] ram_q_reg;
    logic [MSG_W-1:0]  msgq [QUEUE_DEPTH];

    logic               clr_busy_reg, clr_busy_next;
    logic [DRAM_AW-1:0] clr_addr_reg, clr_addr_next;

    logic [QIDX_W-1:0]  q_head_reg, q_head_next;
    logic [QCNT_W-1:0]  q_count_reg, q_count_next;
    logic [1:0]         hs_state_reg, hs_state_next;
    logic [MSG_W-1:0]   mbox_reg, mbox_next;
    logic               rdy_reg, rdy_next;
    logic [DATA_W-1:0]  rst_word_reg, rst_word_next;
    logic [DATA_W-1:0]  ack_word_reg, ack_word_next;

    logic               out_valid_reg, out_valid_next;
    logic               out_sel_ram_reg;
    logic [DATA_W-1:0]  out_val_reg;
    logic [DATA_W-1:0]  reg_val;

    logic               out_free;
    logic               q_load;
    logic               ram_we;
    logic [DRAM_AW-1:0] ram_waddr;
    logic [DATA_W-1:0]  ram_wdata;

    assign status.clearing = clr_busy_reg;
    assign out_free        = !out_valid_reg || m_ready;
    assign pop             = !cmdq_status.empty && out_free && !clr_busy_reg;
    assign m_valid         = out_valid_reg;
    assign m_read_data     = out_sel_ram_reg ? ram_q_reg : out_val_reg;

    // The clearing sweep owns the write port until it ends; no command is
    // popped meanwhile.
    assign ram_we    = clr_busy_reg || (pop && head_cmd.op == OP_RAM_WR);
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : head_cmd.ram_addr;
    assign ram_wdata = clr_busy_reg ? '0 : head_cmd.wdata;

    always_comb begin
        clr_busy_next = clr_busy_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_busy_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == DRAM_AW'(DATA_RAM_WORDS - 1)) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_comb begin
        unique case (head_cmd.op)
            OP_RD_RESET: reg_val = rst_word_reg;
            OP_RD_READY: reg_val = {{(DATA_W-1){1'b0}}, rdy_reg};
            OP_RD_MBOX:  reg_val = {{(DATA_W-MSG_W){1'b0}}, mbox_reg};
            OP_RD_ACK:   reg_val = ack_word_reg;
            OP_RD_ONE:   reg_val = DATA_W'(1);
            default:     reg_val = '0;
        endcase
    end

    always_comb begin
        q_head_next   = q_head_reg;
        q_count_next  = q_count_reg;
        hs_state_next = hs_state_reg;
        mbox_next     = mbox_reg;
        rdy_next      = rdy_reg;
        rst_word_next = rst_word_reg;
        ack_word_next = ack_word_reg;
        q_load        = 1'b0;
        if (pop && head_cmd.op == OP_RST_WR) begin
            rst_word_next = head_cmd.wdata;
            if (head_cmd.wdata == '0) begin
                // Both messages land in slots zero and one. From idle the first
                // one goes straight to the mailbox.
                q_load = 1'b1;
                if (hs_state_reg == HS_IDLE) begin
                    mbox_next     = MSG_STARTED;
                    rdy_next      = 1'b0;
                    hs_state_next = HS_WAIT_LOW;
                    q_head_next   = QIDX_W'(1);
                    q_count_next  = QCNT_W'(1);
                end else begin
                    q_head_next  = '0;
                    q_count_next = QCNT_W'(2);
                end
            end
        end else if (pop && head_cmd.op == OP_ACK_WR) begin
            ack_word_next = head_cmd.wdata;
            unique case (hs_state_reg)
                HS_WAIT_LOW: begin
                    if (head_cmd.wdata == '0) begin
                        rdy_next      = 1'b1;
                        hs_state_next = HS_WAIT_HIGH;
                    end
                end
                HS_WAIT_HIGH: begin
                    if (head_cmd.wdata == DATA_W'(1)) begin
                        hs_state_next = HS_IDLE;
                        if (q_count_reg != '0) begin
                            mbox_next     = msgq[q_head_reg];
                            rdy_next      = 1'b0;
                            hs_state_next = HS_WAIT_LOW;
                            q_count_next  = q_count_reg - 1'b1;
                            q_head_next   = (q_head_reg == QIDX_W'(QUEUE_DEPTH - 1)) ?
                                            '0 : q_head_reg + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (pop) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            q_head_reg    <= '0;
            q_count_reg   <= '0;
            hs_state_reg  <= HS_IDLE;
            mbox_reg      <= '0;
            rdy_reg       <= 1'b0;
            rst_word_reg  <= '0;
            ack_word_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            clr_busy_reg  <= clr_busy_next;
            clr_addr_reg  <= clr_addr_next;
            q_head_reg    <= q_head_next;
            q_count_reg   <= q_count_next;
            hs_state_reg  <= hs_state_next;
            mbox_reg      <= mbox_next;
            rdy_reg       <= rdy_next;
            rst_word_reg  <= rst_word_next;
            ack_word_reg  <= ack_word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_sel_ram_reg <= (head_cmd.op == OP_RAM_RD);
            out_val_reg     <= reg_val;
        end
        if (q_load) begin
            msgq[QIDX_W'(0)] <= MSG_STARTED;
            msgq[QIDX_W'(1)] <= MSG_FINISHED;
        end
    end

    // Data RAM: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (ram_we) begin
            dram[ram_waddr] <= ram_wdata;
        end
        if (pop && head_cmd.op == OP_RAM_RD) begin
            ram_q_reg <= dram[head_cmd.ram_addr];
        end
    end

    a_no_pop_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        clr_busy_reg |-> !pop)
        else $error("command popped during RAM clearing sweep");

    a_pop_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> out_valid_reg)
        else $error("popped command produced no result");

    a_idle_queue_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        hs_state_reg == HS_IDLE |-> q_count_reg == '0)
        else $error("mailbox idle while messages are queued");

    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("message queue count beyond depth");

endmodule

`default_nettype wire
